FILE: hw/rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and counter helpers for the bitmap page frame allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bpfa_pkg;

  localparam int BIT_W  = 5;
  localparam int WORD_W = 1 << BIT_W;
  localparam int ACT_W  = 3;
  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int DELTA_W = BIT_W + 1;

  localparam int NUM_PAGES_DEF = 4096;
  localparam int ADDR_LIMIT    = 4096;

  localparam logic [CNT_W-1:0] CNT_MAX      = 13'd8191;
  localparam logic [CNT_W-1:0] MANAGED_RST  = 13'd4096;

  localparam logic [ACT_W-1:0] ACT_REQUEST   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOCK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESERVE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UNRESERVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_INIT      = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_MODIFY,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic init;
    logic clear;
    logic read;
    logic modify;
    logic update;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             skip;
    logic             more;
    logic             clear_last;
    logic             out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [DELTA_W-1:0] d);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W + 1)'(d);
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] v,
                                               input logic [DELTA_W-1:0] d);
    return (v >= CNT_W'(d)) ? (v - CNT_W'(d)) : '0;
  endfunction

endpackage

FILE: hw/rtl/bpfa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the page bitmap one word per row.
module bpfa_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bpfa_ctrl.sv
`timescale 1ns / 1ps
// Allocator sequencer: clears the bitmap; walks scan items through read, modify, update.
// Depends on bpfa_pkg; drives commands into bpfa_dp and reads its status.
module bpfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpfa_pkg::stat_t     stat,
  output bpfa_pkg::cmd_t      cmd
);
  import bpfa_pkg::*;

  state_t state_r, state_nxt;
  logic   from_init_r, from_init_nxt;
  logic   scan_act;

  // actions that walk the bitmap word by word
  assign scan_act = (stat.act == ACT_REQUEST) || (stat.act == ACT_FREE) ||
                    (stat.act == ACT_LOCK) || (stat.act == ACT_RESERVE) ||
                    (stat.act == ACT_UNRESERVE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      from_init_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_init_r <= from_init_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    from_init_nxt = from_init_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = from_init_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (stat.act == ACT_INIT) begin
          state_nxt     = ST_CLEAR;
          from_init_nxt = 1'b1;
        end else if (scan_act && !stat.skip) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ:   state_nxt = ST_MODIFY;
      ST_MODIFY: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = stat.more ? ST_READ : ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt     = ST_IDLE;
          from_init_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR:  cmd.clear   = 1'b1;
      ST_IDLE:   cmd.capture = in_valid;
      ST_START: begin
        cmd.init  = (stat.act == ACT_INIT);
        cmd.setup = scan_act && !stat.skip;
      end
      ST_READ:   cmd.read    = 1'b1;
      ST_MODIFY: cmd.modify  = 1'b1;
      ST_UPDATE: cmd.update  = 1'b1;
      ST_DONE:   cmd.emit    = stat.out_free;
      default:   cmd         = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bpfa_dp.sv
`timescale 1ns / 1ps
// Datapath: bitmap RAM, page counters, search hint, item and result registers.
// Depends on bpfa_pkg and bpfa_ram; steered by bpfa_ctrl.
module bpfa_dp #(
  parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpfa_pkg::cmd_t                cmd,
  output bpfa_pkg::stat_t               stat,
  input  logic                          cfg_wr_en,
  input  logic [bpfa_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic [bpfa_pkg::ACT_W-1:0]    in_action,
  input  logic [bpfa_pkg::PAGE_W-1:0]   in_first_page,
  input  logic [bpfa_pkg::CNT_W-1:0]    in_run_length,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [bpfa_pkg::PAGE_W-1:0]   out_granted_page,
  output logic [bpfa_pkg::CNT_W-1:0]    out_free_pages,
  output logic [bpfa_pkg::CNT_W-1:0]    out_used_pages,
  output logic [bpfa_pkg::CNT_W-1:0]    out_reserved_pages
);
  import bpfa_pkg::*;

  localparam int DEPTH = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = PAGE_W - BIT_W;
  localparam int XW    = (AW > PW) ? AW : PW;
  localparam logic [CNT_W-1:0] CAP =
    CNT_W'((NUM_PAGES < ADDR_LIMIT) ? NUM_PAGES : ADDR_LIMIT);

  logic [CNT_W-1:0]   managed_r;
  logic [ACT_W-1:0]   act_r;
  logic [PAGE_W-1:0]  first_r;
  logic [CNT_W-1:0]   len_r;
  logic [AW-1:0]      word_r;
  logic [PAGE_W-1:0]  lo_r, lim_r;
  logic [CNT_W-1:0]   hint_r, hint_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   res_r, res_nxt;
  logic [DELTA_W-1:0] delta_r;
  logic               any_r;
  logic [BIT_W-1:0]   low_r;
  logic               grant_r;
  logic [PAGE_W-1:0]  gpage_r;
  logic               out_valid_r;

  logic [CNT_W-1:0]   eff;
  logic [CNT_W:0]     run_end, end_c;
  logic               is_req, is_up, req_skip, run_skip;
  logic [PAGE_W-1:0]  lo_c, lim_c;
  logic [XW-1:0]      wcur, wlo, wlim, wlo_c;
  logic               last_word;
  logic [WORD_W-1:0]  ones, lo_mask, hi_mask, range_mask;
  logic [WORD_W-1:0]  rdata, cand, changed, new_word;
  logic [DELTA_W-1:0] pop;
  logic [BIT_W-1:0]   low_c;
  logic [PAGE_W-1:0]  hit_page;

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (cmd.clear | cmd.modify),
    .waddr (word_r),
    .wdata (cmd.clear ? '0 : new_word),
    .re    (cmd.read),
    .raddr (word_r),
    .rdata (rdata)
  );

  // page count actually in force
  assign eff = (managed_r > CAP) ? CAP : managed_r;

  assign is_req  = (act_r == ACT_REQUEST);
  assign is_up   = (act_r == ACT_FREE) || (act_r == ACT_UNRESERVE);
  assign run_end = {2'b00, first_r} + {1'b0, len_r};
  assign end_c   = (run_end > {1'b0, eff}) ? {1'b0, eff} : run_end;

  assign req_skip = (hint_r >= eff);
  assign run_skip = ({2'b00, first_r} >= end_c);
  assign lo_c     = is_req ? hint_r[PAGE_W-1:0] : first_r;
  assign lim_c    = is_req ? PAGE_W'(eff - 1'b1) : PAGE_W'(end_c - 1'b1);

  assign wcur      = XW'(word_r);
  assign wlo       = XW'(lo_r >> BIT_W);
  assign wlim      = XW'(lim_r >> BIT_W);
  assign wlo_c     = XW'(lo_c >> BIT_W);
  assign last_word = (wcur == wlim);

  // bits of the current word that lie inside the page window
  assign ones       = '1;
  assign lo_mask    = (wcur == wlo) ? (ones << lo_r[BIT_W-1:0]) : ones;
  assign hi_mask    = last_word ? (ones >> (~lim_r[BIT_W-1:0])) : ones;
  assign range_mask = lo_mask & hi_mask;

  assign cand = ~rdata & range_mask;

  always_comb begin
    case (act_r)
      ACT_REQUEST:               changed = cand & (~cand + 1'b1);
      ACT_FREE, ACT_UNRESERVE:   changed = rdata & range_mask;
      ACT_LOCK, ACT_RESERVE:     changed = cand;
      default:                   changed = '0;
    endcase
    new_word = is_up ? (rdata & ~changed) : (rdata | changed);
  end

  always_comb begin
    pop   = '0;
    low_c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pop = pop + DELTA_W'(changed[i]);
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (changed[i]) begin
        low_c = BIT_W'(i);
      end
    end
  end

  assign hit_page = PAGE_W'({word_r, low_r});

  // counter and hint updates
  always_comb begin
    free_nxt = free_r;
    used_nxt = used_r;
    res_nxt  = res_r;
    hint_nxt = hint_r;
    if (cmd.init) begin
      free_nxt = eff;
      used_nxt = '0;
      res_nxt  = '0;
      hint_nxt = '0;
    end else if (cmd.update) begin
      free_nxt = is_up ? sat_add(free_r, delta_r) : sat_sub(free_r, delta_r);
      case (act_r)
        ACT_REQUEST: begin
          used_nxt = sat_add(used_r, delta_r);
          if (any_r) begin
            hint_nxt = {1'b0, hit_page};
          end else if (last_word && (hint_r < eff)) begin
            hint_nxt = eff;
          end
        end
        ACT_FREE: begin
          used_nxt = sat_sub(used_r, delta_r);
          if (any_r && ({1'b0, hit_page} < hint_r)) begin
            hint_nxt = {1'b0, hit_page};
          end
        end
        ACT_UNRESERVE: begin
          res_nxt = sat_sub(res_r, delta_r);
          if (any_r && ({1'b0, hit_page} < hint_r)) begin
            hint_nxt = {1'b0, hit_page};
          end
        end
        ACT_LOCK:    used_nxt = sat_add(used_r, delta_r);
        ACT_RESERVE: res_nxt  = sat_add(res_r, delta_r);
        default:     free_nxt = free_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r   <= MANAGED_RST;
      hint_r      <= '0;
      free_r      <= '0;
      used_r      <= '0;
      res_r       <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        managed_r <= cfg_wr_data;
      end
      hint_r <= hint_nxt;
      free_r <= free_nxt;
      used_r <= used_nxt;
      res_r  <= res_nxt;
      if (cmd.init) begin
        word_r <= '0;
      end else if (cmd.setup) begin
        word_r <= AW'(wlo_c);
      end else if (cmd.clear || (cmd.update && stat.more)) begin
        word_r <= word_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_action;
      first_r <= in_first_page;
      len_r   <= in_run_length;
      grant_r <= 1'b0;
      gpage_r <= '0;
    end else if (cmd.update && is_req && any_r) begin
      grant_r <= 1'b1;
      gpage_r <= hit_page;
    end
    if (cmd.setup) begin
      lo_r  <= lo_c;
      lim_r <= lim_c;
    end
    if (cmd.modify) begin
      delta_r <= pop;
      any_r   <= |changed;
      low_r   <= low_c;
    end
    if (cmd.emit) begin
      out_granted        <= grant_r;
      out_granted_page   <= gpage_r;
      out_free_pages     <= free_r;
      out_used_pages     <= used_r;
      out_reserved_pages <= res_r;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.act        = act_r;
  assign stat.skip       = is_req ? req_skip : run_skip;
  assign stat.more       = !(is_req && any_r) && !last_word;
  assign stat.clear_last = (word_r == AW'(DEPTH - 1));
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

FILE: hw/rtl/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the bitmap page frame allocator: controller plus datapath.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_dp (and bpfa_ram through it).
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  action, first_page, run_length
//   out_*       out  out_valid/out_stall granted, granted_page, free/used/reserved
//   cfg_*       in   cfg_wr_en          managed_pages (cfg_wr_data)
//
// One item at a time. out_valid rises once the item has walked its W words, W being
// the number of 32-page bitmap words walked (none for an empty run or an unused action);
// one RAM read-modify-write per word. in_stall drops in the cycle the result appears.
// Init: out_valid rises after the bitmap is cleared, one word cleared per cycle.
// After reset the same clearing sweep runs with in_stall high.
// A stalled result sits in the output register; the next item is accepted meanwhile.
module bitmap_page_frame_allocator_core #(
  parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpfa_pkg::ACT_W-1:0]    in_action,
  input  logic [bpfa_pkg::PAGE_W-1:0]   in_first_page,
  input  logic [bpfa_pkg::CNT_W-1:0]    in_run_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_granted,
  output logic [bpfa_pkg::PAGE_W-1:0]   out_granted_page,
  output logic [bpfa_pkg::CNT_W-1:0]    out_free_pages,
  output logic [bpfa_pkg::CNT_W-1:0]    out_used_pages,
  output logic [bpfa_pkg::CNT_W-1:0]    out_reserved_pages,
  input  logic                          cfg_wr_en,
  input  logic [bpfa_pkg::CNT_W-1:0]    cfg_wr_data
);
  import bpfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpfa_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_action          (in_action),
    .in_first_page      (in_first_page),
    .in_run_length      (in_run_length),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_granted        (out_granted),
    .out_granted_page   (out_granted_page),
    .out_free_pages     (out_free_pages),
    .out_used_pages     (out_used_pages),
    .out_reserved_pages (out_reserved_pages)
  );

  // a beat taken in must block the port while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input port open right after an accepted beat");

  // a word is only modified on the cycle after its read
  a_modify_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.modify |-> $past(cmd.read))
    else $error("bitmap modify without preceding read");

  // results that grant nothing carry page zero
  a_no_grant_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_granted_page == '0))
    else $error("ungranted result with non-zero page");

  // the RAM is never written and read in the same cycle by the sequencer
  a_single_ram_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.read, cmd.modify, cmd.clear}))
    else $error("overlapping bitmap RAM commands");

endmodule
